[rtl/pus_packet_builder_hdlc_framer_defines.svh]
// ----------------------------------------------------------------------------
// PUS packet builder defines
// Assertion macros used by the top-level framer file to check the framer.
// ----------------------------------------------------------------------------
`ifndef PUS_PACKET_BUILDER_HDLC_FRAMER_DEFINES_SVH
`define PUS_PACKET_BUILDER_HDLC_FRAMER_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define PUSB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause
`define PUSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pusb_pkg.sv]
// ----------------------------------------------------------------------------
// PUS packet builder package
// Framing constants, defaults and the command passed from front to back.
// ----------------------------------------------------------------------------
package pusb_pkg;

	// Framing and stuffing bytes
	localparam logic [7:0] FLAG_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE  = 8'h7D;
	localparam logic [7:0] ESC_FLAG  = 8'h5E;
	localparam logic [7:0] ESC_ESC   = 8'h5D;
	localparam logic [7:0] PAD_BYTE  = 8'h00;

	// Header field constants
	localparam logic [1:0] SEQ_SINGLE  = 2'd3;
	localparam logic [3:0] HDR_VER_NIB = 4'h8;
	localparam logic [3:0] PUS_VER_NIB = 4'h1;
	localparam logic [15:0] LEN_OFFSET = 16'd5;

	// Item and packet kinds
	localparam logic REQ_HDR  = 1'b0;
	localparam logic REQ_DATA = 1'b1;
	localparam logic PKT_TM   = 1'b0;
	localparam logic PKT_TC   = 1'b1;

	// Command body geometry
	localparam int HDR_BYTES  = 10;
	localparam int BODY_IDX_W = $clog2(HDR_BYTES);
	localparam logic [BODY_IDX_W-1:0] HDR_LAST_IDX  = BODY_IDX_W'(HDR_BYTES - 1);
	localparam logic [BODY_IDX_W-1:0] DATA_LAST_IDX = '0;

	// Parameter defaults
	localparam int NUM_APPS_DEF    = 8;
	localparam int MAX_PAYLOAD_DEF = 255;
	localparam int CMDQ_DEPTH_DEF  = 4;
	localparam logic [2:0] OWN_APP_RESET = 3'd1;

	// One unit of work for the byte emitter
	typedef struct packed {
		logic                              is_hdr;   // opening flag first
		logic                              tail;     // pad, checksum, close after body
		logic [BODY_IDX_W-1:0]             last_idx; // index of final body byte
		logic [7:0]                        csum;
		logic [HDR_BYTES-1:0][7:0]         body;
	} cmd_t;

endpackage

[rtl/pus_packet_builder_hdlc_framer.sv]
// ----------------------------------------------------------------------------
// PUS packet builder with HDLC framing
// Builds byte-stuffed PUS packet frames from header and payload items.
// ----------------------------------------------------------------------------
// A header item opens a frame and a data item adds one payload byte; the frame
// leaves as one byte per output item, frame_last marking the closing flag. The
// front end takes an item whenever the command queue has a free slot, so input
// bursts of up to the queue depth are absorbed at one item per cycle. The
// emitter puts out one byte per cycle unless frame_stall holds it and fetches
// the next command in the cycle that finishes the current one; the sustained
// rate is set by output bytes: a data item yields one byte, two if stuffed,
// plus three or four when it closes the frame; a header item yields 11 to 15
// bytes (only four header bytes can ever need stuffing), three or four more
// with an empty payload. An idle emitter fetches a command before emitting it.
module pus_packet_builder_hdlc_framer #(
	parameter int NUM_APPS    = pusb_pkg::NUM_APPS_DEF,
	parameter int MAX_PAYLOAD = pusb_pkg::MAX_PAYLOAD_DEF,
	parameter int CMDQ_DEPTH  = pusb_pkg::CMDQ_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        req_type,
	input  logic [2:0]  app_id,
	input  logic        pkt_type,
	input  logic [3:0]  ack_flags,
	input  logic [7:0]  service_type,
	input  logic [7:0]  service_subtype,
	input  logic [2:0]  dest_id,
	input  logic [7:0]  payload_len,
	input  logic [13:0] seq_in,
	input  logic [7:0]  data_byte,
	output logic        frame_valid,
	input  logic        frame_stall,
	output logic [7:0]  frame_byte,
	output logic        frame_last
);

`include "pus_packet_builder_hdlc_framer_defines.svh"

	logic           accept;
	logic           q_push;
	logic           q_pop;
	logic           q_empty;
	logic           q_full;
	pusb_pkg::cmd_t push_cmd;
	pusb_pkg::cmd_t head_cmd;

	// Stall the input while the queue is full
	assign req_stall = q_full;
	assign accept    = req_valid && !req_stall;

	pusb_front #(
		.NUM_APPS    (NUM_APPS),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.accept          (accept),
		.req_type        (req_type),
		.app_id          (app_id),
		.pkt_type        (pkt_type),
		.ack_flags       (ack_flags),
		.service_type    (service_type),
		.service_subtype (service_subtype),
		.dest_id         (dest_id),
		.payload_len     (payload_len),
		.seq_in          (seq_in),
		.data_byte       (data_byte),
		.push            (q_push),
		.cmd             (push_cmd)
	);

	pusb_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	pusb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_cmd    (head_cmd),
		.empty       (q_empty),
		.pop         (q_pop),
		.frame_stall (frame_stall),
		.frame_valid (frame_valid),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last)
	);

	// Closing marker only ever rides on a flag byte
	`PUSB_ASSERT_NOW(a_last_is_flag, frame_valid && frame_last, frame_byte == pusb_pkg::FLAG_BYTE, "frame_last on a non-flag byte")
	// An escape taken is followed at once by its stuffed partner
	`PUSB_ASSERT_NEXT(a_esc_pair, frame_valid && !frame_stall && frame_byte == pusb_pkg::ESC_BYTE, frame_valid && (frame_byte == pusb_pkg::ESC_FLAG || frame_byte == pusb_pkg::ESC_ESC), "escape byte not followed by stuffed byte")
	// The emitter never fetches from an empty queue
	`PUSB_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "command fetched from empty queue")

endmodule

[rtl/pusb_front.sv]
// ----------------------------------------------------------------------------
// PUS packet builder front end
// Accepts items, tracks the open packet and builds emitter commands.
// ----------------------------------------------------------------------------
module pusb_front #(
	parameter int NUM_APPS    = pusb_pkg::NUM_APPS_DEF,
	parameter int MAX_PAYLOAD = pusb_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                accept,
	input  logic                req_type,
	input  logic [2:0]          app_id,
	input  logic                pkt_type,
	input  logic [3:0]          ack_flags,
	input  logic [7:0]          service_type,
	input  logic [7:0]          service_subtype,
	input  logic [2:0]          dest_id,
	input  logic [7:0]          payload_len,
	input  logic [13:0]         seq_in,
	input  logic [7:0]          data_byte,
	output logic                push,
	output pusb_pkg::cmd_t      cmd
);

	localparam int CNT_DEPTH = (NUM_APPS < 8) ? NUM_APPS : 8;
	localparam int CIDX_W    = $clog2(CNT_DEPTH);
	localparam int SAT_LEN   = (MAX_PAYLOAD > 255) ? 255 : MAX_PAYLOAD;

	logic [2:0]        own_app_q;
	logic              open_q;
	logic [7:0]        left_q;
	logic [7:0]        xor_q;
	logic [7:0]        seq_cnt_q [CNT_DEPTH];

	logic [7:0]        plen;
	logic              use_cnt;
	logic [CIDX_W-1:0] cnt_idx;
	logic [13:0]       seq;
	logic [15:0]       len_field;
	logic [7:0]        hdr_xor;
	logic              data_tail;
	logic [7:0]        data_xor;
	pusb_pkg::cmd_t    hdr_cmd;
	pusb_pkg::cmd_t    data_cmd;

	// Wrap a 3-bit id into the counter range
	function automatic logic [2:0] wrap_id(input logic [2:0] id);
		logic [2:0] r;
		r = id;
		for (int k = 0; k < 4; k++) begin
			if (int'(r) >= NUM_APPS) begin
				r = r - 3'(NUM_APPS);
			end
		end
		return r;
	endfunction

	// Classify header: saturate length, pick local counter or input count
	always_comb begin
		logic [2:0] widx;
		plen = (payload_len > 8'(SAT_LEN)) ? 8'(SAT_LEN) : payload_len;
		use_cnt = 1'b0;
		widx = wrap_id(dest_id);
		if (pkt_type == pusb_pkg::PKT_TC && dest_id == own_app_q) begin
			use_cnt = 1'b1;
			widx = wrap_id(app_id);
		end else if (pkt_type == pusb_pkg::PKT_TM && app_id == own_app_q) begin
			use_cnt = 1'b1;
			widx = wrap_id(dest_id);
		end
		cnt_idx = widx[CIDX_W-1:0];
		seq = use_cnt ? {6'd0, seq_cnt_q[cnt_idx]} : seq_in;
		len_field = {8'd0, plen} + pusb_pkg::LEN_OFFSET;
	end

	// Assemble the ten header bytes and their checksum
	always_comb begin
		hdr_cmd = '0;
		hdr_cmd.is_hdr   = 1'b1;
		hdr_cmd.last_idx = pusb_pkg::HDR_LAST_IDX;
		hdr_cmd.body[0]  = {3'd0, pkt_type, pusb_pkg::HDR_VER_NIB};
		hdr_cmd.body[1]  = {5'd0, app_id};
		hdr_cmd.body[2]  = {pusb_pkg::SEQ_SINGLE, seq[13:8]};
		hdr_cmd.body[3]  = seq[7:0];
		hdr_cmd.body[4]  = len_field[15:8];
		hdr_cmd.body[5]  = len_field[7:0];
		hdr_cmd.body[6]  = (pkt_type == pusb_pkg::PKT_TC) ?
			{pusb_pkg::PUS_VER_NIB, ack_flags} : {pusb_pkg::PUS_VER_NIB, 4'd0};
		hdr_cmd.body[7]  = service_type;
		hdr_cmd.body[8]  = service_subtype;
		hdr_cmd.body[9]  = {5'd0, dest_id};
		hdr_xor = '0;
		for (int i = 0; i < pusb_pkg::HDR_BYTES; i++) begin
			hdr_xor = hdr_xor ^ hdr_cmd.body[i];
		end
		hdr_cmd.csum = hdr_xor;
		hdr_cmd.tail = (plen == 8'd0);
	end

	// Build a payload command; the last expected byte closes the frame
	always_comb begin
		data_xor  = xor_q ^ data_byte;
		data_tail = (left_q <= 8'd1);
		data_cmd = '0;
		data_cmd.is_hdr   = 1'b0;
		data_cmd.tail     = data_tail;
		data_cmd.last_idx = pusb_pkg::DATA_LAST_IDX;
		data_cmd.csum     = data_xor;
		data_cmd.body[0]  = data_byte;
	end

	// Drop orphan data, forward everything else
	assign push = accept && (req_type == pusb_pkg::REQ_HDR || open_q);
	assign cmd  = (req_type == pusb_pkg::REQ_HDR) ? hdr_cmd : data_cmd;

	// Hold configuration and packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_app_q <= pusb_pkg::OWN_APP_RESET;
			open_q    <= 1'b0;
			left_q    <= '0;
			xor_q     <= '0;
			for (int i = 0; i < CNT_DEPTH; i++) begin
				seq_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				own_app_q <= cfg_wdata;
			end
			if (accept && req_type == pusb_pkg::REQ_HDR) begin
				open_q <= (plen != 8'd0);
				left_q <= plen;
				xor_q  <= hdr_xor;
				if (use_cnt) begin
					seq_cnt_q[cnt_idx] <= seq_cnt_q[cnt_idx] + 8'd1;
				end
			end else if (accept && open_q) begin
				xor_q <= data_xor;
				if (data_tail) begin
					open_q <= 1'b0;
					left_q <= '0;
				end else begin
					left_q <= left_q - 8'd1;
				end
			end
		end
	end

endmodule

[rtl/pusb_cmdq.sv]
// ----------------------------------------------------------------------------
// PUS packet builder command queue
// Short FIFO that decouples command building from byte emission.
// ----------------------------------------------------------------------------
module pusb_cmdq #(
	parameter int DEPTH = pusb_pkg::CMDQ_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pusb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output pusb_pkg::cmd_t head_cmd,
	output logic           empty,
	output logic           full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pusb_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign head_cmd = slot_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/pusb_back.sv]
// ----------------------------------------------------------------------------
// PUS packet builder byte emitter
// Walks each command byte by byte, stuffs, and drives the output register.
// ----------------------------------------------------------------------------
module pusb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pusb_pkg::cmd_t head_cmd,
	input  logic           empty,
	output logic           pop,
	input  logic           frame_stall,
	output logic           frame_valid,
	output logic [7:0]     frame_byte,
	output logic           frame_last
);

	typedef enum logic [2:0] {
		PH_OPEN,
		PH_BODY,
		PH_PAD,
		PH_CSUM,
		PH_CLOSE
	} phase_t;

	phase_t                            phase_q;
	logic                              busy_q;
	logic                              esc_q;
	logic [pusb_pkg::BODY_IDX_W-1:0]   idx_q;
	pusb_pkg::cmd_t                    cmd_q;
	logic                              out_valid_q;
	logic [7:0]                        out_byte_q;
	logic                              out_last_q;

	logic       can_load;
	logic       step;
	logic [7:0] raw;
	logic       need_esc;
	logic [7:0] emit;
	logic       advance;
	logic       finish;

	// Select the raw byte of the current phase
	always_comb begin
		case (phase_q)
			PH_OPEN:  raw = pusb_pkg::FLAG_BYTE;
			PH_BODY:  raw = cmd_q.body[idx_q];
			PH_PAD:   raw = pusb_pkg::PAD_BYTE;
			PH_CSUM:  raw = cmd_q.csum;
			PH_CLOSE: raw = pusb_pkg::FLAG_BYTE;
			default:  raw = pusb_pkg::FLAG_BYTE;
		endcase
	end

	// Stuff flag and escape bytes inside the frame
	always_comb begin
		need_esc = (phase_q inside {PH_BODY, PH_PAD, PH_CSUM}) &&
			(raw == pusb_pkg::FLAG_BYTE || raw == pusb_pkg::ESC_BYTE);
		if (esc_q) begin
			emit = (raw == pusb_pkg::FLAG_BYTE) ? pusb_pkg::ESC_FLAG : pusb_pkg::ESC_ESC;
		end else if (need_esc) begin
			emit = pusb_pkg::ESC_BYTE;
		end else begin
			emit = raw;
		end
	end

	assign can_load = !out_valid_q || !frame_stall;
	assign step     = busy_q && can_load;
	assign advance  = step && (esc_q || !need_esc);
	assign finish   = advance && (phase_q == PH_CLOSE ||
		(phase_q == PH_BODY && idx_q == cmd_q.last_idx && !cmd_q.tail));
	assign pop      = !empty && (!busy_q || finish);

	assign frame_valid = out_valid_q;
	assign frame_byte  = out_byte_q;
	assign frame_last  = out_last_q;

	// Sequence the phases and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OPEN;
			busy_q      <= 1'b0;
			esc_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (can_load) begin
				out_valid_q <= step;
			end
			if (step) begin
				out_byte_q <= emit;
				out_last_q <= (phase_q == PH_CLOSE);
			end
			// Load the next command, or advance within the current one
			if (pop) begin
				cmd_q   <= head_cmd;
				busy_q  <= 1'b1;
				idx_q   <= '0;
				esc_q   <= 1'b0;
				phase_q <= head_cmd.is_hdr ? PH_OPEN : PH_BODY;
			end else begin
				if (finish) begin
					busy_q <= 1'b0;
				end
				if (step) begin
					esc_q <= !esc_q && need_esc;
				end
				if (advance) begin
					case (phase_q)
						PH_OPEN: begin
							phase_q <= PH_BODY;
							idx_q   <= '0;
						end
						PH_BODY: begin
							if (idx_q == cmd_q.last_idx) begin
								phase_q <= PH_PAD;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						PH_PAD:   phase_q <= PH_CSUM;
						PH_CSUM:  phase_q <= PH_CLOSE;
						PH_CLOSE: phase_q <= PH_OPEN;
						default:  phase_q <= PH_OPEN;
					endcase
				end
			end
		end
	end

endmodule
